// ===== hw/rtl/mcfe_pkg.sv =====
package mcfe_pkg;

	localparam int unsigned SpeedWidth = 16;
	localparam int unsigned ByteWidth  = 8;
	localparam int unsigned MagWidth   = 7;
	localparam int unsigned DigitWidth = 4;
	localparam int unsigned MotorCount = 4;
	localparam int unsigned FrameBytes = 22;

	localparam logic signed [SpeedWidth-1:0] SpeedMax = 16'sd100;
	localparam logic signed [SpeedWidth-1:0] SpeedMin = -16'sd100;
	localparam logic [MagWidth-1:0]          MagFull  = 7'd100;

	localparam logic [ByteWidth-1:0] CharZero    = 8'h30;
	localparam logic [ByteWidth-1:0] CharReverse = 8'h52;
	localparam logic [ByteWidth-1:0] CharForward = 8'h46;
	localparam logic [ByteWidth-1:0] CharCr      = 8'h0D;
	localparam logic [ByteWidth-1:0] CharLf      = 8'h0A;

	// Byte position inside one motor's five-byte group, then the line ending
	typedef enum logic [2:0] {
		POS_INDEX,
		POS_DIR,
		POS_HUND,
		POS_TENS,
		POS_ONES,
		POS_CR,
		POS_LF
	} pos_t;

	// Decimal form of one motor speed
	typedef struct packed {
		logic                  reverse;
		logic                  hund;
		logic [DigitWidth-1:0] tens;
		logic [DigitWidth-1:0] ones;
	} motor_code_t;

	typedef motor_code_t [MotorCount-1:0] frame_code_t;

endpackage

// ===== hw/rtl/mcfe_cmd_if.sv =====
interface mcfe_cmd_if;
	import mcfe_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [SpeedWidth-1:0] speed_one;
	logic signed [SpeedWidth-1:0] speed_two;
	logic signed [SpeedWidth-1:0] speed_three;
	logic signed [SpeedWidth-1:0] speed_four;

	modport source (
		output valid, speed_one, speed_two, speed_three, speed_four,
		input  ready
	);

	modport sink (
		input  valid, speed_one, speed_two, speed_three, speed_four,
		output ready
	);

endinterface

// ===== hw/rtl/mcfe_byte_if.sv =====
interface mcfe_byte_if;
	import mcfe_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ByteWidth-1:0] frame_byte;
	logic                 frame_end;

	modport source (
		output valid, frame_byte, frame_end,
		input  ready
	);

	modport sink (
		input  valid, frame_byte, frame_end,
		output ready
	);

endinterface

// ===== hw/rtl/mcfe_speed_enc.sv =====
module mcfe_speed_enc (
	input  logic signed [mcfe_pkg::SpeedWidth-1:0] speed,
	output mcfe_pkg::motor_code_t                  code
);
	import mcfe_pkg::*;

	logic                       in_rev;
	logic                       in_fwd;
	logic [SpeedWidth-1:0]      neg_speed;
	logic [MagWidth-1:0]        mag;
	logic [MagWidth+ByteWidth-1:0] tens_prod;
	logic [DigitWidth-1:0]      tens_raw;
	logic [MagWidth-1:0]        tens_x10;
	logic [MagWidth-1:0]        ones_full;

	// Classify the speed; anything out of range encodes as forward zero
	always_comb begin
		in_rev    = (speed < 0) && (speed >= SpeedMin);
		in_fwd    = (speed >= 0) && (speed <= SpeedMax);
		neg_speed = SpeedWidth'(-speed);
		if (in_rev) begin
			mag = neg_speed[MagWidth-1:0];
		end else if (in_fwd) begin
			mag = speed[MagWidth-1:0];
		end else begin
			mag = '0;
		end
	end

	// Split magnitude into digits: divide by ten as multiply by 205, shift 11
	always_comb begin
		tens_prod = (MagWidth+ByteWidth)'(mag) * (MagWidth+ByteWidth)'(205);
		tens_raw  = tens_prod[MagWidth+ByteWidth-1:11];
		tens_x10  = MagWidth'({tens_raw, 3'b000}) + MagWidth'({tens_raw, 1'b0});
		ones_full = mag - tens_x10;

		code.reverse = in_rev;
		code.hund    = (mag == MagFull);
		code.tens    = code.hund ? '0 : tens_raw;
		code.ones    = ones_full[DigitWidth-1:0];
	end

endmodule

// ===== hw/rtl/mcfe_frame_ser.sv =====
module mcfe_frame_ser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load_valid,
	input  mcfe_pkg::frame_code_t  load_code,
	output logic                   load_ready,
	mcfe_byte_if.source            frame
);
	import mcfe_pkg::*;

	frame_code_t          code_q;
	logic                 busy_q;
	pos_t                 pos_q;
	logic [1:0]           motor_q;
	logic                 out_valid_q;
	logic [ByteWidth-1:0] out_byte_q;
	logic                 out_end_q;

	logic                 advance;
	logic                 emit;
	logic                 last_byte;
	motor_code_t          cur;
	logic [ByteWidth-1:0] next_byte;

	assign advance    = !out_valid_q || frame.ready;
	assign emit       = advance && busy_q;
	assign last_byte  = (pos_q == POS_LF);
	assign load_ready = !busy_q || (emit && last_byte);
	assign cur        = code_q[motor_q];

	// Pick the byte at the current frame position
	always_comb begin
		unique case (pos_q)
			POS_INDEX: next_byte = CharZero + ByteWidth'(motor_q) + ByteWidth'(1);
			POS_DIR:   next_byte = cur.reverse ? CharReverse : CharForward;
			POS_HUND:  next_byte = CharZero + ByteWidth'(cur.hund);
			POS_TENS:  next_byte = CharZero + ByteWidth'(cur.tens);
			POS_ONES:  next_byte = CharZero + ByteWidth'(cur.ones);
			POS_CR:    next_byte = CharCr;
			POS_LF:    next_byte = CharLf;
			default:   next_byte = CharLf;
		endcase
	end

	// Walk the frame: five bytes per motor, then CR and LF
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pos_q   <= POS_INDEX;
			motor_q <= '0;
		end else if (load_valid && load_ready) begin
			busy_q  <= 1'b1;
			pos_q   <= POS_INDEX;
			motor_q <= '0;
		end else if (emit) begin
			if (last_byte) begin
				busy_q <= 1'b0;
			end else if (pos_q == POS_ONES && motor_q != 2'd3) begin
				pos_q   <= POS_INDEX;
				motor_q <= motor_q + 2'd1;
			end else begin
				pos_q <= pos_t'(pos_q + 3'd1);
			end
		end
	end

	// Hold the encoded frame while it drains
	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			code_q <= load_code;
		end
	end

	// Output register: take the next beat whenever the sink frees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= next_byte;
			out_end_q  <= last_byte;
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.frame_byte = out_byte_q;
	assign frame.frame_end  = out_end_q;

endmodule

// ===== hw/rtl/motor_command_frame_encoder_unit.sv =====
// Four-channel motor command frame encoder. Each beat on cmd carries four
// signed speeds and yields 22 beats on frame, one ASCII byte each: per motor
// the digit 1 to 4, 'R' (speed -100 to -1) or 'F', and the magnitude as three
// zero-padded digits; then CR and LF, where frame_end is set. Speeds outside
// -100 to 100 encode as F000. Output runs at one byte per cycle while the
// sink holds frame.ready high, through the single byte-wide output register.
// One command waits in the input register while the previous frame drains,
// so the next frame follows the last LF with no gap. A command accepted into
// an idle unit passes the input register and the serializer load before its
// first byte reaches the output register.
module motor_command_frame_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	mcfe_cmd_if.sink    cmd,
	mcfe_byte_if.source frame
);
	import mcfe_pkg::*;

	logic                         cmd_valid_s1;
	logic signed [SpeedWidth-1:0] speed_s1 [MotorCount];
	frame_code_t                  code;
	logic                         load_ready;

	// Input register: free when empty or when its command moves on
	assign cmd.ready = !cmd_valid_s1 || load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			cmd_valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			speed_s1[0] <= cmd.speed_one;
			speed_s1[1] <= cmd.speed_two;
			speed_s1[2] <= cmd.speed_three;
			speed_s1[3] <= cmd.speed_four;
		end
	end

	// Encode each speed into direction and decimal digits
	for (genvar m = 0; m < MotorCount; m++) begin : g_enc
		mcfe_speed_enc u_enc (
			.speed (speed_s1[m]),
			.code  (code[m])
		);
	end

	mcfe_frame_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (cmd_valid_s1),
		.load_code  (code),
		.load_ready (load_ready),
		.frame      (frame)
	);

endmodule
